@@ src/edf_pkg.sv @@
package edf_pkg;

  // input word modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // one task table entry as held in the task memory
  typedef struct packed {
    logic [7:0]  job_length;
    logic [7:0]  task_period;
    logic [7:0]  work_left;
    logic [31:0] abs_deadline;
  } task_entry_t;

  // one output word
  typedef struct packed {
    logic        ran_valid;
    logic [3:0]  ran_task;
    logic        job_done;
    logic [15:0] missed_mask;
    logic [15:0] miss_total;
    logic [31:0] time_now;
  } result_t;

endpackage

@@ src/edf_task_mem.sv @@
module edf_task_mem
  import edf_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  task_entry_t   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output task_entry_t   rdata
);

  task_entry_t mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/edf_ctrl.sv @@
module edf_ctrl
  import edf_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [3:0]       task_index,
  input  logic [7:0]       exec_time,
  input  logic [7:0]       period,
  input  logic [CNT_W-1:0] n_tasks,
  input  logic             slot_free,
  output logic             res_push,
  output result_t          res,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output task_entry_t      mem_wdata,
  output logic             mem_re,
  output logic [IDX_W-1:0] mem_raddr,
  input  task_entry_t      mem_rdata
);

  localparam int IW = ((CNT_W > 4) ? CNT_W : 4) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SCAN2 = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state;
  logic             cur_mode;
  logic [31:0]      tick_time;
  logic [15:0]      miss_counter;
  logic [CNT_W-1:0] cnt_rd;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_k;
  logic             found;
  logic [IDX_W-1:0] best;
  logic [7:0]       best_dist;
  task_entry_t      best_ent;
  logic             ran_valid_r;
  logic [3:0]       ran_task_r;
  logic             job_done_r;
  logic [15:0]      mask_r;

  logic             accept;
  logic [IW-1:0]    load_idx_w;
  logic             load_ok;
  logic [7:0]       ex_fix;
  logic [7:0]       per_fix;
  logic [31:0]      next_time;
  logic [31:0]      dl_gap;
  logic             cand;
  logic             better;
  logic [7:0]       best_wl_dec;
  logic             miss_hit;
  logic [IW-1:0]    rd_k_w;
  logic [IW-1:0]    best_w;
  logic             scan_end;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign load_idx_w = IW'(task_index);
  assign load_ok    = (load_idx_w < IW'(MAX_TASKS));
  assign ex_fix     = (exec_time == 8'd0) ? 8'd1 : exec_time;
  assign per_fix    = (period == 8'd0) ? 8'd1 : period;
  assign next_time  = tick_time + 32'd1;

  // candidate test for the earliest deadline scan
  assign dl_gap = mem_rdata.abs_deadline - tick_time;
  assign cand   = (mem_rdata.work_left != 8'd0) && (dl_gap[31:8] == 24'd0) &&
                  (dl_gap[7:0] <= mem_rdata.task_period);
  assign better = cand && (!found || (dl_gap[7:0] < best_dist));

  // deadline miss test for the second scan
  assign miss_hit = rd_vld && (mem_rdata.work_left != 8'd0) &&
                    (mem_rdata.abs_deadline == next_time);

  assign best_wl_dec = best_ent.work_left - 8'd1;
  assign rd_k_w      = IW'(rd_k);
  assign best_w      = IW'(best);
  assign scan_end    = (cnt_rd == n_tasks);

  // read issue during both scans
  assign mem_re    = ((state == S_SCAN1) || (state == S_SCAN2)) && (cnt_rd < n_tasks);
  assign mem_raddr = cnt_rd[IDX_W-1:0];

  // write port: load, update of the task that ran, miss advance
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_k;
    mem_wdata = mem_rdata;
    unique case (state)
      S_IDLE: begin
        mem_we                 = accept && (mode == MODE_LOAD) && load_ok;
        mem_waddr              = load_idx_w[IDX_W-1:0];
        mem_wdata.job_length   = ex_fix;
        mem_wdata.task_period  = per_fix;
        mem_wdata.work_left    = ex_fix;
        mem_wdata.abs_deadline = tick_time + 32'(per_fix);
      end
      S_UPD: begin
        mem_we    = found;
        mem_waddr = best;
        mem_wdata = best_ent;
        if (best_wl_dec == 8'd0) begin
          mem_wdata.work_left    = best_ent.job_length;
          mem_wdata.abs_deadline = best_ent.abs_deadline + 32'(best_ent.task_period);
        end else begin
          mem_wdata.work_left = best_wl_dec;
        end
      end
      S_SCAN2: begin
        mem_we                 = miss_hit;
        mem_waddr              = rd_k;
        mem_wdata              = mem_rdata;
        mem_wdata.work_left    = mem_rdata.job_length;
        mem_wdata.abs_deadline = mem_rdata.abs_deadline + 32'(mem_rdata.task_period);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // result word
  assign res_push        = (state == S_FIN) && slot_free;
  assign res.ran_valid   = ran_valid_r;
  assign res.ran_task    = ran_task_r;
  assign res.job_done    = job_done_r;
  assign res.missed_mask = mask_r;
  assign res.miss_total  = miss_counter;
  assign res.time_now    = (cur_mode == MODE_TICK) ? next_time : tick_time;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tick_time    <= 32'd0;
      miss_counter <= 16'd0;
      rd_vld       <= 1'b0;
      found        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_mode    <= mode;
            cnt_rd      <= '0;
            rd_vld      <= 1'b0;
            found       <= 1'b0;
            ran_valid_r <= 1'b0;
            ran_task_r  <= 4'd0;
            job_done_r  <= 1'b0;
            mask_r      <= 16'd0;
            if ((mode == MODE_TICK) && (n_tasks != '0)) begin
              state <= S_SCAN1;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN1: begin
          rd_vld <= mem_re;
          rd_k   <= mem_raddr;
          cnt_rd <= cnt_rd + CNT_W'(mem_re);
          if (rd_vld && better) begin
            found     <= 1'b1;
            best      <= rd_k;
            best_dist <= dl_gap[7:0];
            best_ent  <= mem_rdata;
          end
          if (scan_end) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          cnt_rd <= '0;
          rd_vld <= 1'b0;
          if (found) begin
            ran_valid_r <= 1'b1;
            ran_task_r  <= best_w[3:0];
            job_done_r  <= (best_wl_dec == 8'd0);
          end
          state <= S_SCAN2;
        end
        S_SCAN2: begin
          rd_vld <= mem_re;
          rd_k   <= mem_raddr;
          cnt_rd <= cnt_rd + CNT_W'(mem_re);
          if (miss_hit) begin
            if (rd_k_w < IW'(16)) begin
              mask_r[rd_k_w[3:0]] <= 1'b1;
            end
            if (miss_counter != 16'hFFFF) begin
              miss_counter <= miss_counter + 16'd1;
            end
          end
          if (scan_end) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            if (cur_mode == MODE_TICK) begin
              tick_time <= next_time;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a miss write never hits the entry being read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("task memory read and write to the same entry");

  // the read counter stays within the active task range during scans
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN1) || (state == S_SCAN2)) |-> (cnt_rd <= n_tasks))
    else $error("scan counter past task count");

  // a finished job implies that a task ran
  a_done_ran: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!res.job_done || res.ran_valid))
    else $error("job done without a running task");

  // miss count only grows
  a_miss_mono: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (miss_counter >= $past(miss_counter)))
    else $error("miss counter decreased");

endmodule

@@ src/edf_tick_scheduler_top.sv @@
// a load word goes from accept straight to the result state; a tick word runs two scans over N = active tasks
// (a tick with no active task goes straight to the result state like a load)
// a tick reads every active entry twice through the single task memory read port,
// once for the earliest deadline and once for deadline misses, one entry per cycle
// one word in flight at a time; a new word is accepted while the result register is full;
// reset (rst, synchronous) clears time, miss count and handshake state, task_count to 1;
// task table undefined until loaded
module edf_tick_scheduler_top
  import edf_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [3:0]  task_index,
  input  logic [7:0]  exec_time,
  input  logic [7:0]  period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ran_valid,
  output logic [3:0]  ran_task,
  output logic        job_done,
  output logic [15:0] missed_mask,
  output logic [15:0] miss_total,
  output logic [31:0] time_now
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

  logic [4:0]       task_count;
  logic [CMP_W-1:0] count_w;
  logic [CNT_W-1:0] n_tasks;
  logic             slot_free;
  logic             res_push;
  result_t          res;
  result_t          out_res;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  task_entry_t      mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  task_entry_t      mem_rdata;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= 5'd1;
    end else if (cfg_wr_en) begin
      task_count <= cfg_wr_data;
    end
  end

  // active task count clamped to the table depth
  assign count_w = CMP_W'(task_count);
  assign n_tasks = (count_w > CMP_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : CNT_W'(task_count);

  // output register
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

  assign ran_valid   = out_res.ran_valid;
  assign ran_task    = out_res.ran_task;
  assign job_done    = out_res.job_done;
  assign missed_mask = out_res.missed_mask;
  assign miss_total  = out_res.miss_total;
  assign time_now    = out_res.time_now;

  edf_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .task_index (task_index),
    .exec_time  (exec_time),
    .period     (period),
    .n_tasks    (n_tasks),
    .slot_free  (slot_free),
    .res_push   (res_push),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  edf_task_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ bench/tb_edf_tick_scheduler_top.sv @@
module tb_edf_tick_scheduler_top;
  import edf_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 50;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  // block inputs, known from time zero
  logic        cfg_wr_en   = 1'b0;
  logic [4:0]  cfg_wr_data = 5'd0;
  logic        in_valid    = 1'b0;
  logic        mode        = MODE_LOAD;
  logic [3:0]  task_index  = 4'd0;
  logic [7:0]  exec_time   = 8'd0;
  logic [7:0]  period      = 8'd0;
  logic        out_ready   = 1'b0;

  // block outputs
  logic        in_ready;
  logic        out_valid;
  logic        ran_valid;
  logic [3:0]  ran_task;
  logic        job_done;
  logic [15:0] missed_mask;
  logic [15:0] miss_total;
  logic [31:0] time_now;

  edf_tick_scheduler_top #(
    .MAX_TASKS(TABLE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .task_index (task_index),
    .exec_time  (exec_time),
    .period     (period),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ran_valid  (ran_valid),
    .ran_task   (ran_task),
    .job_done   (job_done),
    .missed_mask(missed_mask),
    .miss_total (miss_total),
    .time_now   (time_now)
  );

  // scheduler copy: task table, clock, miss count, active count
  logic [7:0]  job_len  [TABLE_DEPTH] = '{default: '0};
  logic [7:0]  per_tab  [TABLE_DEPTH] = '{default: '0};
  logic [7:0]  work     [TABLE_DEPTH] = '{default: '0};
  logic [31:0] deadline [TABLE_DEPTH] = '{default: '0};
  logic [31:0] now_t    = 32'd0;
  logic [15:0] misses   = 16'd0;
  logic [4:0]  tc_model = 5'd1;

  // dispatch words still owed by the block, oldest first
  result_t dispatch_due[$];
  result_t want_word;

  int errors    = 0;
  int idle_pct  = 37;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet     = 0;

  // next job of entry k: deadline moves one period, work reloads
  function automatic void roll_job(input int k);
    deadline[k] = deadline[k] + {24'd0, per_tab[k]};
    work[k]     = job_len[k];
  endfunction

  // apply one input word to the scheduler copy and return the word it owes
  function automatic result_t predict_dispatch(input logic m, input logic [3:0] idx,
                                               input logic [7:0] ex, input logic [7:0] per);
    result_t     r;
    int          n;
    bit          found;
    int          best;
    logic [31:0] gap;
    logic [31:0] best_dist;
    logic [31:0] nxt;
    logic [7:0]  e;
    logic [7:0]  p;
    r = '0;
    if (m == MODE_LOAD) begin
      e = (ex == 8'd0) ? 8'd1 : ex;
      p = (per == 8'd0) ? 8'd1 : per;
      job_len[idx]  = e;
      per_tab[idx]  = p;
      work[idx]     = e;
      deadline[idx] = now_t + {24'd0, p};
    end else begin
      n = (tc_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(tc_model);
      found = 1'b0;
      best = 0;
      best_dist = '0;
      // earliest deadline among released entries with work, lower index on ties
      for (int k = 0; k < n; k++) begin
        gap = deadline[k] - now_t;
        if (work[k] != 8'd0 && gap <= {24'd0, per_tab[k]}) begin
          if (!found || gap < best_dist) begin
            found = 1'b1;
            best = k;
            best_dist = gap;
          end
        end
      end
      if (found) begin
        r.ran_valid = 1'b1;
        r.ran_task  = best[3:0];
        work[best]  = work[best] - 8'd1;
        if (work[best] == 8'd0) begin
          r.job_done = 1'b1;
          roll_job(best);
        end
      end
      // deadline reached with work left counts a miss
      nxt = now_t + 32'd1;
      for (int k = 0; k < n; k++) begin
        if (work[k] != 8'd0 && deadline[k] == nxt) begin
          r.missed_mask[k] = 1'b1;
          roll_job(k);
          if (misses != 16'hFFFF) misses = misses + 16'd1;
        end
      end
      now_t = nxt;
    end
    r.miss_total = misses;
    r.time_now   = now_t;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: check each accepted word, then pick the next ready value
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (dispatch_due.size() == 0) begin
          $display("%0t: result word with nothing expected, time_now %0h", $time, time_now);
          errors++;
        end else begin
          want_word = dispatch_due.pop_front();
          check_field("ran_valid", 32'(want_word.ran_valid), 32'(ran_valid));
          check_field("ran_task", 32'(want_word.ran_task), 32'(ran_task));
          check_field("job_done", 32'(want_word.job_done), 32'(job_done));
          check_field("missed_mask", 32'(want_word.missed_mask), 32'(missed_mask));
          check_field("miss_total", 32'(want_word.miss_total), 32'(miss_total));
          check_field("time_now", want_word.time_now, time_now);
        end
      end
      // long hold-off on request, random stalls otherwise
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("[edf_tick_scheduler_top] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // offer one input word, with random idle cycles ahead of it
  task automatic send_word(input logic m, input logic [3:0] idx,
                           input logic [7:0] ex, input logic [7:0] per);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    task_index <= idx;
    exec_time  <= ex;
    period     <= per;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dispatch_due.push_back(predict_dispatch(m, idx, ex, per));
  endtask

  // wait until every owed word has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (dispatch_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_task_count(input logic [4:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    tc_model     = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly ticks, some loads with short periods, now and then full range
  task automatic run_random(input int count);
    logic [7:0] ex;
    logic [7:0] per;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(9) == 0) begin
          ex  = 8'($urandom_range(255));
          per = 8'($urandom_range(255));
        end else begin
          per = 8'($urandom_range(24, 1));
          ex  = 8'($urandom_range(per, 1));
        end
        send_word(MODE_LOAD, 4'($urandom_range(15)), ex, per);
      end else begin
        send_word(MODE_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end
    end
  endtask

  // every entry written before any tick can read it, field extremes included
  task automatic test_load_table;
    send_word(MODE_LOAD, 4'd0, 8'd0, 8'd0);
    send_word(MODE_LOAD, 4'd1, 8'd1, 8'd255);
    send_word(MODE_LOAD, 4'd2, 8'd255, 8'd1);
    for (int i = 3; i < TABLE_DEPTH - 1; i++) begin
      send_word(MODE_LOAD, i[3:0], i[7:0], 8'(2 * i + 3));
    end
    send_word(MODE_LOAD, 4'd15, 8'd255, 8'd255);
  endtask

  // ticks under the reset task count
  task automatic test_reset_count;
    repeat (3) send_word(MODE_TICK, 4'd0, 8'd0, 8'd0);
  endtask

  // equal deadlines go to the lower index, the loser misses
  task automatic test_tie_and_miss;
    set_task_count(5'd3);
    send_word(MODE_LOAD, 4'd0, 8'd1, 8'd8);
    send_word(MODE_LOAD, 4'd1, 8'd3, 8'd4);
    send_word(MODE_LOAD, 4'd2, 8'd3, 8'd4);
    repeat (6) send_word(MODE_TICK, 4'hF, 8'hFF, 8'hFF);
  endtask

  // several task counts, zero and above the table size among them
  task automatic test_random_schedule;
    logic [4:0] counts [8] = '{5'd2, 5'd5, 5'd16, 5'd0, 5'd31, 5'd8, 5'd1, 5'd17};
    foreach (counts[i]) begin
      set_task_count(counts[i]);
      run_random(110);
    end
  endtask

  // receiver holds off while words keep coming, input must stall
  task automatic test_output_stall;
    set_task_count(5'd16);
    hold_req <= hold_req + 1;
    run_random(120);
  endtask

  // both sides without idle cycles
  task automatic test_no_idle;
    set_task_count(5'd4);
    idle_pct = 0;
    run_random(100);
    idle_pct = 37;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_table();
    test_reset_count();
    test_tie_and_miss();
    test_random_schedule();
    test_output_stall();
    test_no_idle();
    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (errors == 0) begin
      $display("[edf_tick_scheduler_top] OK");
    end else begin
      $display("[edf_tick_scheduler_top] ERROR");
    end
    $finish;
  end

endmodule
